// ===== src/mrwb_pkg.sv =====
// shared types and constants for the max-rgb white balance block
`timescale 1ns / 1ps

package mrwb_pkg;

  // command codes
  localparam logic [1:0] CMD_MEASURE = 2'd0;
  localparam logic [1:0] CMD_CORRECT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       cmd;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
  } out_beat_t;

  // correct job: pixel plus the maxima in force when it was accepted
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] peak_blue;
    logic [PIX_W-1:0] peak_green;
    logic [PIX_W-1:0] peak_red;
  } job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== src/mrwb_queue.sv =====
// short job queue between the front and back parts
`timescale 1ns / 1ps

module mrwb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mrwb_pkg::job_t     push_job,
  input  logic               pop,
  output mrwb_pkg::job_t     pop_job,
  output mrwb_pkg::queue_stat_t stat
);
  import mrwb_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QUEUE_CW'(1);
      end
    end
  end

endmodule

// ===== src/mrwb_front.sv =====
// front part: takes input beats, tracks channel maxima, queues correct jobs
`timescale 1ns / 1ps

module mrwb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mrwb_pkg::in_beat_t    in_data,
  input  mrwb_pkg::queue_stat_t q_stat,
  output logic                  q_push,
  output mrwb_pkg::job_t        q_job
);
  import mrwb_pkg::*;

  logic [PIX_W-1:0] peak_blue_r;
  logic [PIX_W-1:0] peak_green_r;
  logic [PIX_W-1:0] peak_red_r;
  logic             accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (in_data.cmd == CMD_CORRECT);

  assign q_job.blue       = in_data.blue;
  assign q_job.green      = in_data.green;
  assign q_job.red        = in_data.red;
  assign q_job.peak_blue  = peak_blue_r;
  assign q_job.peak_green = peak_green_r;
  assign q_job.peak_red   = peak_red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_blue_r  <= '0;
      peak_green_r <= '0;
      peak_red_r   <= '0;
    end else if (accept) begin
      case (in_data.cmd)
        CMD_MEASURE: begin
          if (in_data.blue > peak_blue_r) begin
            peak_blue_r <= in_data.blue;
          end
          if (in_data.green > peak_green_r) begin
            peak_green_r <= in_data.green;
          end
          if (in_data.red > peak_red_r) begin
            peak_red_r <= in_data.red;
          end
        end
        CMD_CLEAR: begin
          peak_blue_r  <= '0;
          peak_green_r <= '0;
          peak_red_r   <= '0;
        end
        default: begin
          // correct goes to the queue, unused code does nothing
        end
      endcase
    end
  end

endmodule

// ===== src/mrwb_back.sv =====
// back part: multiply, bit-serial divide and result register
`timescale 1ns / 1ps

module mrwb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mrwb_pkg::queue_stat_t q_stat,
  input  mrwb_pkg::job_t        q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mrwb_pkg::out_beat_t   out_data
);
  import mrwb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  localparam int CNT_W = $clog2(PIX_W);

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  job_t               job_r;
  logic [2*PIX_W-1:0] prod_b_r;
  logic [2*PIX_W-1:0] prod_r_r;
  logic [PIX_W-1:0]   rem_b_r;
  logic [PIX_W-1:0]   rem_r_r;
  logic [PIX_W-1:0]   quo_b_r;
  logic [PIX_W-1:0]   quo_r_r;
  logic               sat_b_r;
  logic               sat_r_r;
  logic               out_valid_r;
  out_beat_t          out_data_r;
  logic [2*PIX_W-1:0] step_b_nxt;
  logic [2*PIX_W-1:0] step_r_nxt;

  // one restoring step: remainder stays below den, quotient bit shifts in
  function automatic logic [2*PIX_W-1:0] div_step(input logic [PIX_W-1:0] rem,
                                                  input logic [PIX_W-1:0] quo,
                                                  input logic [PIX_W-1:0] den);
    logic [PIX_W:0] rem_sh;
    logic [PIX_W:0] diff;
    rem_sh = {rem, quo[PIX_W-1]};
    diff   = rem_sh - {1'b0, den};
    if (rem_sh >= {1'b0, den}) begin
      div_step = {diff[PIX_W-1:0], quo[PIX_W-2:0], 1'b1};
    end else begin
      div_step = {rem_sh[PIX_W-1:0], quo[PIX_W-2:0], 1'b0};
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick(input logic             sat,
                                            input logic [PIX_W-1:0] den,
                                            input logic [PIX_W-1:0] quo);
    if (den == '0) begin
      pick = '0;
    end else if (sat) begin
      pick = '1;
    end else begin
      pick = quo;
    end
  endfunction

  assign step_b_nxt = div_step(rem_b_r, quo_b_r, job_r.peak_blue);
  assign step_r_nxt = div_step(rem_r_r, quo_r_r, job_r.peak_red);

  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the result load below decides the valid bit
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job_r   <= q_job;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_b_r <= {{PIX_W{1'b0}}, job_r.blue} * {{PIX_W{1'b0}}, job_r.peak_green};
          prod_r_r <= {{PIX_W{1'b0}}, job_r.red} * {{PIX_W{1'b0}}, job_r.peak_green};
          state_r  <= S_PREP;
        end
        S_PREP: begin
          // high byte at or above den means the quotient will not fit
          sat_b_r <= (prod_b_r[2*PIX_W-1:PIX_W] >= job_r.peak_blue);
          sat_r_r <= (prod_r_r[2*PIX_W-1:PIX_W] >= job_r.peak_red);
          rem_b_r <= prod_b_r[2*PIX_W-1:PIX_W];
          rem_r_r <= prod_r_r[2*PIX_W-1:PIX_W];
          quo_b_r <= prod_b_r[PIX_W-1:0];
          quo_r_r <= prod_r_r[PIX_W-1:0];
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          {rem_b_r, quo_b_r} <= step_b_nxt;
          {rem_r_r, quo_r_r} <= step_r_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(PIX_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.out_blue  <= pick(sat_b_r, job_r.peak_blue, quo_b_r);
            out_data_r.out_green <= job_r.green;
            out_data_r.out_red   <= pick(sat_r_r, job_r.peak_red, quo_r_r);
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/max_rgb_white_balance.sv =====
// top level of the max-rgb white balance block
//
//  channel | ports                          | beat contents
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | cmd, blue, green, red
//  result  | out_valid, out_ready, out_data | out_blue, out_green, out_red
//
// measure, clear and unused beats are taken one per cycle while the queue has room.
// a correct beat goes through the back part in order: pop, multiply, prep, 8 divide
// steps of the one-bit-per-cycle divider, result load; up to 4 jobs queue.
// reset is synchronous, active low, and empties the queue and zeroes the maxima.
// a stalled result holds in the output register; the front keeps running until
// the queue fills, then in_ready drops.
`timescale 1ns / 1ps

module max_rgb_white_balance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrwb_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrwb_pkg::out_beat_t out_data
);
  import mrwb_pkg::*;

  queue_stat_t q_stat;
  logic        q_push;
  logic        q_pop;
  job_t        push_job;
  job_t        pop_job;

  mrwb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  mrwb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  mrwb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/mrwb_chk.sv =====
// port-level checks for the max-rgb white balance block
`timescale 1ns / 1ps

module mrwb_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mrwb_pkg::out_beat_t out_data
);
  import mrwb_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // reset empties the result register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no result can get through the pipeline right after reset is released
  a_rst_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_valid)
    else $error("result too soon after reset");

  // the queue is empty right after reset, so input is taken
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready || !in_valid || !rst_n)
    else $error("input stalled right after reset");

endmodule

bind max_rgb_white_balance mrwb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_max_rgb_white_balance.sv =====
// self-checking testbench for the max-rgb white balance block
`timescale 1ns / 1ps

module tb_max_rgb_white_balance;
  import mrwb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RAND_ITEMS = 1150;

  typedef struct {
    in_beat_t beat;
    bit       drain;  // hold this beat back until every pending pixel is out
  } pix_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  max_rgb_white_balance dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pix_req_t    pix_todo[$];
  out_beat_t   want_pix[$];
  logic [7:0]  peak_b = '0, peak_g = '0, peak_r = '0;
  int unsigned n_offered = 0, n_taken = 0, n_results = 0, seen_results = 0;
  int unsigned gap_left = 0, stall_left = 0, cycles = 0;
  int unsigned n_meas = 0, n_corr = 0, n_clr = 0, n_unused = 0;
  int unsigned n_bad = 0, n_items = 0;
  bit          src_burst = 1'b0, sink_burst = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // floor(s * num / den), saturated, zero when the maximum is zero
  function automatic logic [7:0] scale_ch(input logic [7:0] s, input logic [7:0] num,
                                          input logic [7:0] den);
    logic [15:0] q;
    if (den == 8'd0) return 8'd0;
    q = (16'(s) * 16'(num)) / 16'(den);
    return (q > 16'd255) ? 8'hff : q[7:0];
  endfunction

  function automatic out_beat_t balance_pixel(input in_beat_t px);
    out_beat_t o;
    o.out_blue  = scale_ch(px.blue, peak_g, peak_b);
    o.out_green = px.green;
    o.out_red   = scale_ch(px.red, peak_g, peak_r);
    return o;
  endfunction

  task automatic add_pix(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] g,
                         input logic [7:0] r, input bit drain);
    pix_req_t p;
    p.beat.cmd   = cmd;
    p.beat.blue  = b;
    p.beat.green = g;
    p.beat.red   = r;
    p.drain      = drain;
    pix_todo = {pix_todo, p};
    if (cmd != CMD_UNUSED) n_items++;
  endtask

  task automatic report_bad(input string what, input out_beat_t want, input out_beat_t got);
    n_bad++;
    if (n_bad <= 10)
      $display("mismatch (%s) at cycle %0d: want b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
               what, cycles, want.out_blue, want.out_green, want.out_red,
               got.out_blue, got.out_green, got.out_red);
  endtask

  // sender: one beat per handshake, random gap drawn per beat
  always @(negedge clk) begin
    pix_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_taken == n_offered) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pix_todo.size() != 0 && !(pix_todo[0].drain && want_pix.size() != 0)) begin
        nxt = pix_todo.pop_front();
        in_data   <= nxt.beat;
        in_valid  <= 1'b1;
        n_offered <= n_offered + 1;
        gap_left  <= src_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 63) == 0) src_burst <= ~src_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall drawn per result beat
  always @(negedge clk) begin
    int unsigned d;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (n_results != seen_results) begin
      seen_results <= n_results;
      d = sink_burst ? 0 : $urandom_range(0, 16);
      stall_left <= d;
      out_ready  <= (d == 0);
      if ($urandom_range(0, 31) == 0) sink_burst <= ~sink_burst;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results first, then fold accepted input beats into the predictor
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (want_pix.size() == 0) begin
          report_bad("unexpected", '0, out_data);
        end else begin
          want = want_pix.pop_front();
          if (out_data.out_blue !== want.out_blue || out_data.out_green !== want.out_green ||
              out_data.out_red !== want.out_red)
            report_bad("field", want, out_data);
        end
      end
      if (in_valid && in_ready) begin
        n_taken <= n_taken + 1;
        case (in_data.cmd)
          CMD_MEASURE: begin
            n_meas++;
            if (in_data.blue > peak_b) peak_b = in_data.blue;
            if (in_data.green > peak_g) peak_g = in_data.green;
            if (in_data.red > peak_r) peak_r = in_data.red;
          end
          CMD_CORRECT: begin
            n_corr++;
            want_pix = {want_pix, balance_pixel(in_data)};
          end
          CMD_CLEAR: begin
            n_clr++;
            peak_b = '0;
            peak_g = '0;
            peak_r = '0;
          end
          default: n_unused++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles, want_pix.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned kind, nm, nc;
    logic [7:0]  cb, cg, cr;

    // directed: zero maxima right after reset
    add_pix(CMD_CORRECT, 8'd200, 8'd100, 8'd50, 1'b0);
    add_pix(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(CMD_CORRECT, 8'hff, 8'h00, 8'hff, 1'b0);
    // full-scale maxima
    add_pix(CMD_MEASURE, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(CMD_MEASURE, 8'h00, 8'h00, 8'h00, 1'b0);
    add_pix(CMD_CORRECT, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(CMD_CORRECT, 8'h00, 8'h00, 8'h00, 1'b0);
    // small blue/red maxima against a big green one: saturation
    add_pix(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1);
    add_pix(CMD_MEASURE, 8'd10, 8'hff, 8'd1, 1'b0);
    add_pix(CMD_CORRECT, 8'd200, 8'd7, 8'd200, 1'b0);
    add_pix(CMD_CORRECT, 8'd10, 8'd0, 8'd1, 1'b0);
    add_pix(CMD_CORRECT, 8'd9, 8'haa, 8'd0, 1'b0);
    // unused command must leave the maxima alone
    add_pix(CMD_UNUSED, 8'h55, 8'h00, 8'haa, 1'b0);
    add_pix(CMD_CORRECT, 8'd5, 8'h55, 8'd1, 1'b0);
    // zero green maximum
    add_pix(CMD_CLEAR, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(CMD_MEASURE, 8'd50, 8'd0, 8'd60, 1'b0);
    add_pix(CMD_CORRECT, 8'd50, 8'd9, 8'd60, 1'b0);
    // zero blue and red maxima, nonzero green
    add_pix(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);
    add_pix(CMD_MEASURE, 8'd0, 8'd128, 8'd0, 1'b0);
    add_pix(CMD_CORRECT, 8'd77, 8'd33, 8'd199, 1'b0);
    // sample above its maximum after a drained queue
    add_pix(CMD_MEASURE, 8'd100, 8'd200, 8'd3, 1'b1);
    add_pix(CMD_CORRECT, 8'd150, 8'd201, 8'hff, 1'b0);
    n_items = 0;

    // random: mostly clear / measure run / correct run, some noise beats
    while (n_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        add_pix(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end else begin
        if ($urandom_range(0, 3) == 0)
          add_pix(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(0, 30) == 0);
        cb = ($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom);
        cg = ($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom);
        cr = ($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom);
        nm = $urandom_range(0, 10);
        nc = $urandom_range(1, 8);
        repeat (nm)
          add_pix(CMD_MEASURE, 8'($urandom_range(0, cb)), 8'($urandom_range(0, cg)),
                  8'($urandom_range(0, cr)), 1'b0);
        repeat (nc) begin
          if ($urandom_range(0, 3) != 0)
            add_pix(CMD_CORRECT, 8'($urandom_range(0, cb)), 8'($urandom),
                    8'($urandom_range(0, cr)), 1'b0);
          else
            add_pix(CMD_CORRECT, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pix_todo.size() != 0 || n_taken != n_offered) @(posedge clk);
    while (want_pix.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d beats in: %0d measure, %0d correct, %0d clear, %0d unused",
             n_taken, n_meas, n_corr, n_clr, n_unused);
    $display("%0d corrected pixels checked, %0d mismatches", n_results, n_bad);
    if (n_bad == 0 && want_pix.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mrwb_pkg.sv
src/mrwb_queue.sv
src/mrwb_front.sv
src/mrwb_back.sv
src/max_rgb_white_balance.sv
src/mrwb_chk.sv
dv/tb_max_rgb_white_balance.sv
